>>> hw/rtl/xmodem_checksum_receiver_macros.svh
// Assertion macros for the XMODEM checksum receiver.
// Used by the RTL files that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef XMODEM_CHECKSUM_RECEIVER_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_MACROS_SVH

// Property checked at every rising clock edge, off while in reset.
`define XMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true.
`define XMC_ASSERT_NEVER(label, cond, msg) \
  `XMC_ASSERT(label, !(cond), msg)

`endif

>>> hw/rtl/xmc_pkg.sv
// Types and constants shared by the XMODEM checksum receiver.
// No dependencies; imported by xmc_core and xmodem_checksum_receiver.
package xmc_pkg;

  localparam int BlockBytes = 128;
  localparam int IdxW       = $clog2(BlockBytes);
  localparam int LenW       = 16;
  localparam int PaddrW     = 3;
  localparam int PdataW     = 32;

  localparam logic [7:0] CharSoh   = 8'h01;
  localparam logic [7:0] CharEot   = 8'h04;
  localparam logic [7:0] CharCan   = 8'h18;
  localparam logic [7:0] ComplMask = 8'hFF;

  localparam logic [LenW-1:0] BufferSizeRst = 16'hFFFF;
  localparam logic [7:0]      RetryLimitRst = 8'd10;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_BYTE    = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RPL_NONE = 2'd0,
    RPL_ACK  = 2'd1,
    RPL_NAK  = 2'd2,
    RPL_CAN  = 2'd3
  } reply_e;

  typedef enum logic [1:0] {
    OUT_RUNNING = 2'd0,
    OUT_SUCCESS = 2'd1,
    OUT_FAILURE = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SOH  = 3'd1,
    PH_BLK  = 3'd2,
    PH_INV  = 3'd3,
    PH_DATA = 3'd4,
    PH_SUM  = 3'd5,
    PH_DONE = 3'd6
  } phase_e;

  typedef enum logic {
    REG_BUFFER_SIZE = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic [1:0]      reply;
    logic            write_enable;
    logic [LenW-1:0] write_address;
    logic [7:0]      write_data;
    logic            finished;
    logic [1:0]      outcome;
    logic [LenW-1:0] received_length;
  } out_res_t;

  typedef struct packed {
    logic [LenW-1:0] buffer_size;
    logic [7:0]      retry_limit;
  } cfg_t;

  typedef struct packed {
    phase_e          phase;
    logic [7:0]      block_number;
    logic [7:0]      block_complement;
    logic [7:0]      expected_block;
    logic [7:0]      retry_count;
    logic [IdxW-1:0] byte_index;
    logic [7:0]      running_sum;
    logic [LenW-1:0] committed_length;
  } state_t;

  localparam cfg_t CfgRst = '{buffer_size: BufferSizeRst, retry_limit: RetryLimitRst};

  localparam state_t StateRst = '{
    phase:            PH_IDLE,
    block_number:     8'd0,
    block_complement: 8'd0,
    expected_block:   8'd1,
    retry_count:      8'd0,
    byte_index:       '0,
    running_sum:      8'd0,
    committed_length: '0
  };

endpackage

>>> hw/rtl/xmc_core.sv
// Single-pass protocol step: next receiver state and the result for one request.
// Purely combinational; depends on xmc_pkg.
module xmc_core import xmc_pkg::*; (
  input  cfg_t     cfg_i,
  input  state_t   state_i,
  input  in_req_t  req_i,
  output state_t   state_o,
  output out_res_t res_o
);

  logic [7:0]    rx;
  logic          live;
  logic [7:0]    retry_inc;
  logic          retry_hit;
  logic          soh_retry_ok;
  logic          hdr_bad;
  logic          sum_bad;
  logic          blk_dup;
  logic          blk_wrong;
  logic          idx_last;
  logic [LenW:0] addr_sum;
  logic          addr_fits;
  logic [LenW-1:0] room;
  logic [LenW-1:0] copy;

  assign rx           = req_i.rx_byte;
  assign live         = (state_i.phase != PH_IDLE) && (state_i.phase != PH_DONE);
  assign retry_inc    = state_i.retry_count + 8'd1;
  assign retry_hit    = retry_inc >= cfg_i.retry_limit;
  assign soh_retry_ok = (state_i.committed_length == '0) &&
                        (state_i.retry_count < cfg_i.retry_limit);
  assign hdr_bad      = (state_i.block_number ^ rx) != ComplMask;
  assign sum_bad      = rx != state_i.running_sum;
  assign blk_dup      = state_i.block_number == (state_i.expected_block - 8'd1);
  assign blk_wrong    = state_i.block_number != state_i.expected_block;
  assign idx_last     = state_i.byte_index == IdxW'(BlockBytes - 1);
  assign addr_sum     = {1'b0, state_i.committed_length} + (LenW+1)'(state_i.byte_index);
  assign addr_fits    = addr_sum < {1'b0, cfg_i.buffer_size};
  assign room         = (cfg_i.buffer_size > state_i.committed_length) ?
                        (cfg_i.buffer_size - state_i.committed_length) : '0;
  assign copy         = (room < LenW'(BlockBytes)) ? room : LenW'(BlockBytes);

  // next state
  always_comb begin
    state_o = state_i;
    case (req_i.action)
      ACT_START: begin
        state_o = '0;
        state_o.phase          = PH_SOH;
        state_o.expected_block = 8'd1;
      end
      ACT_TIMEOUT: begin
        if (live) begin
          if (state_i.phase == PH_SOH) begin
            if (soh_retry_ok) begin
              state_o.retry_count = retry_inc;
            end else begin
              state_o.phase = PH_DONE;
            end
          end else begin
            state_o.retry_count = retry_inc;
            state_o.phase       = retry_hit ? PH_DONE : PH_SOH;
          end
        end
      end
      ACT_BYTE: begin
        if (live) begin
          case (state_i.phase)
            PH_SOH: begin
              if (rx == CharEot || rx == CharCan) begin
                state_o.phase = PH_DONE;
              end else if (rx == CharSoh) begin
                state_o.phase = PH_BLK;
              end
            end
            PH_BLK: begin
              state_o.block_number = rx;
              state_o.phase        = PH_INV;
            end
            PH_INV: begin
              state_o.block_complement = rx;
              if (hdr_bad) begin
                state_o.retry_count = retry_inc;
                state_o.phase       = retry_hit ? PH_DONE : PH_SOH;
              end else begin
                state_o.byte_index  = '0;
                state_o.running_sum = '0;
                state_o.phase       = PH_DATA;
              end
            end
            PH_DATA: begin
              state_o.running_sum = state_i.running_sum + rx;
              state_o.byte_index  = state_i.byte_index + IdxW'(1);
              if (idx_last) begin
                state_o.phase = PH_SUM;
              end
            end
            PH_SUM: begin
              state_o.byte_index = '0;
              if (sum_bad) begin
                state_o.retry_count = retry_inc;
                state_o.phase       = retry_hit ? PH_DONE : PH_SOH;
              end else if (blk_dup) begin
                state_o.phase = PH_SOH;
              end else if (blk_wrong) begin
                state_o.phase = PH_DONE;
              end else begin
                state_o.committed_length = state_i.committed_length + copy;
                state_o.expected_block   = state_i.expected_block + 8'd1;
                state_o.retry_count      = '0;
                state_o.phase            = PH_SOH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    logic ok;
    logic fail;
    ok    = 1'b0;
    fail  = 1'b0;
    res_o = '0;
    res_o.received_length = state_o.committed_length;
    case (req_i.action)
      ACT_START: begin
        res_o.reply = RPL_NAK;
      end
      ACT_TIMEOUT: begin
        if (live) begin
          if (state_i.phase == PH_SOH) begin
            if (soh_retry_ok) begin
              res_o.reply = RPL_NAK;
            end else begin
              fail = 1'b1;
            end
          end else begin
            res_o.reply = RPL_NAK;
            fail        = retry_hit;
          end
        end
      end
      ACT_BYTE: begin
        if (live) begin
          case (state_i.phase)
            PH_SOH: begin
              if (rx == CharEot) begin
                res_o.reply = RPL_ACK;
                ok          = 1'b1;
              end else if (rx == CharCan) begin
                fail = 1'b1;
              end
            end
            PH_INV: begin
              if (hdr_bad) begin
                res_o.reply = RPL_NAK;
                fail        = retry_hit;
              end
            end
            PH_DATA: begin
              if (addr_fits) begin
                res_o.write_enable  = 1'b1;
                res_o.write_address = addr_sum[LenW-1:0];
                res_o.write_data    = rx;
              end
            end
            PH_SUM: begin
              if (sum_bad) begin
                res_o.reply = RPL_NAK;
                fail        = retry_hit;
              end else if (blk_dup) begin
                res_o.reply = RPL_ACK;
              end else if (blk_wrong) begin
                res_o.reply = RPL_CAN;
                fail        = 1'b1;
              end else begin
                res_o.reply = RPL_ACK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    res_o.finished = ok | fail;
    res_o.outcome  = ok ? OUT_SUCCESS : (fail ? OUT_FAILURE : OUT_RUNNING);
  end

endmodule

>>> hw/rtl/xmodem_checksum_receiver.sv
// XMODEM receiver with 8-bit additive checksum. Each request is a start command, a received
// byte or a timeout, and gives exactly one result: the reply byte to send, an optional write
// into the destination buffer, the end-of-transfer flag and outcome, and the committed length.
// A request is held in the input register and moves to the result register when that register
// is free or its result is being taken; the result register presents the result until taken.
// One request is accepted every cycle unless a held result stalls both registers, since the
// whole protocol step is a single combinational pass over the state registers. The APB port sets
// buffer_size (address 0) and retry_limit (address 4) and should be written only while idle.
// Depends on xmc_pkg, xmc_core and xmodem_checksum_receiver_macros.svh.
`include "xmodem_checksum_receiver_macros.svh"

module xmodem_checksum_receiver import xmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_req_t           in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_res_t          out_res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg_q, cfg_d;
  state_t   state_q, state_d;
  logic     s1_valid_q, s1_valid_d;
  in_req_t  s1_req_q, s1_req_d;
  logic     out_valid_q, out_valid_d;
  out_res_t out_res_q, out_res_d;
  out_res_t res;
  logic     adv;
  logic     in_acc;
  logic     cfg_wr;
  reg_e     reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_BUFFER_SIZE: cfg_d.buffer_size = pwdata[LenW-1:0];
        REG_RETRY_LIMIT: cfg_d.retry_limit = pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BUFFER_SIZE: prdata = PdataW'(cfg_q.buffer_size);
      REG_RETRY_LIMIT: prdata = PdataW'(cfg_q.retry_limit);
      default:         prdata = '0;
    endcase
  end

  xmc_core u_core (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .req_i   (s1_req_q),
    .state_o (state_d),
    .res_o   (res)
  );

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_req_d   = s1_req_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
      s1_req_d   = in_req_i;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (adv) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgRst;
      state_q     <= StateRst;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_req_q  <= s1_req_d;
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  `XMC_ASSERT(a_adv_fills_out, adv |=> out_valid_q, "stepped request produced no result")
  `XMC_ASSERT(a_finish_ends, (adv && res.finished) |=> (state_q.phase == PH_DONE),
              "finished result without ending the transfer")
  `XMC_ASSERT(a_s1_holds, (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_req_q)),
              "held request lost or changed")
  `XMC_ASSERT_NEVER(a_no_return_idle,
                    $past(state_q.phase) != PH_IDLE && state_q.phase == PH_IDLE,
                    "receiver returned to idle after starting")

endmodule
